>>> rtl/length_prefixed_list_deframer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the length-prefixed list deframer
// Wrappers around concurrent assertions clocked on clk.
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_LIST_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_LIST_DEFRAMER_MACROS_SVH

// Check on every clock edge outside reset.
`define LPLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define LPLD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lpld_pkg.sv
// ---------------------------------------------------------------------------
// lpld_pkg
// Shared types and codes of the length-prefixed list deframer.
// ---------------------------------------------------------------------------
package lpld_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

  localparam int PREFIX_BYTES = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic       last_result;
    logic [1:0] error_code;
    logic       item_end;
    logic [7:0] item_index;
    logic [7:0] payload_byte;
    logic       has_byte;
  } result_t;

  // Up to two results caused by one input item.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } core_out_t;

endpackage

>>> rtl/length_prefixed_list_deframer.sv
// An accepted input item is held in the input register; its results pass through the result
// queue to m_*. Throughput: one input item per cycle while each causes at most one result and
// m_tready is high; an item that ends one item and starts the next may cause two results, and
// the four-entry result queue then drains them at one per cycle while m_tready is high.
// Reset (rst, synchronous): empties the input register and result queue,
// returns the deframer to idle and sets item_count to 1.
// ---------------------------------------------------------------------------
// length_prefixed_list_deframer
// Splits a byte stream into items, each but the last with a four-byte big-endian length prefix.
// ---------------------------------------------------------------------------
module length_prefixed_list_deframer #(
  parameter int LENGTH_BITS = 32,
  parameter int INDEX_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,     // item_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,      // total_length[31:0], data_byte[39:32]
  input  logic [0:0]  s_tuser,      // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // payload_byte[7:0], item_index[15:8]
  output logic [3:0]  m_tuser,      // has_byte[0], error_code[2:1], last_result[3]
  output logic        m_tlast       // item_end
);

  logic        in_valid;
  logic        in_opcode;
  logic [31:0] in_length;
  logic [7:0]  in_byte;
  logic        adv;

  lpld_pkg::core_out_t core_res;
  lpld_pkg::result_t   fifo_mem [lpld_pkg::FIFO_DEPTH];
  lpld_pkg::result_t   head;
  logic [lpld_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [lpld_pkg::FIFO_AW:0]   count;
  logic [1:0]                   push;
  logic                         pop;

  // Advance only when the queue can take two results
  assign adv      = in_valid && (count <= (lpld_pkg::FIFO_AW + 1)'(lpld_pkg::FIFO_DEPTH - 2));
  assign s_tready = !in_valid || adv;
  assign push     = adv ? core_res.count : 2'd0;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode <= s_tuser[0];
      in_length <= s_tdata[31:0];
      in_byte   <= s_tdata[39:32];
    end
  end

  lpld_core #(
    .LENGTH_BITS (LENGTH_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .step        (adv),
    .step_opcode (in_opcode),
    .step_length (in_length),
    .step_byte   (in_byte),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= lpld_pkg::FIFO_AW'(wr_ptr + push);
      rd_ptr <= lpld_pkg::FIFO_AW'(rd_ptr + pop);
      count  <= (lpld_pkg::FIFO_AW + 1)'(count + push - pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      fifo_mem[wr_ptr] <= core_res.first;
    end
    if (push == 2'd2) begin
      fifo_mem[lpld_pkg::FIFO_AW'(wr_ptr + 1'b1)] <= core_res.second;
    end
  end

  assign head     = fifo_mem[rd_ptr];
  assign m_tvalid = (count != '0);
  assign m_tdata  = {head.item_index, head.payload_byte};
  assign m_tuser  = {head.last_result, head.error_code, head.has_byte};
  assign m_tlast  = head.item_end;

endmodule

>>> rtl/lpld_core.sv
// ---------------------------------------------------------------------------
// lpld_core
// Deframing state and the per-item step that yields up to two results.
// ---------------------------------------------------------------------------
module lpld_core #(
  parameter int LENGTH_BITS = 32,
  parameter int INDEX_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                step,
  input  logic                step_opcode,
  input  logic [31:0]         step_length,
  input  logic [7:0]          step_byte,
  output lpld_pkg::core_out_t res
);

  typedef enum logic [1:0] {PH_IDLE, PH_PREFIX, PH_BODY, PH_HALT} phase_t;

  phase_t                 phase, phase_next;
  logic [7:0]             item_count;
  logic [7:0]             current_item, current_item_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [LENGTH_BITS-1:0] item_bytes_left, item_bytes_left_next;
  logic [23:0]            length_shift, length_shift_next;
  logic [1:0]             prefix_count, prefix_count_next;

  logic [LENGTH_BITS-1:0] rem_dec, ibl_dec, bg_rem;
  logic [31:0]            len, rem_dec_ext;
  logic                   len_big, cur_last, start;
  logic [7:0]             bg_ci;
  logic                   bg_last, bg_empty, bg_short, bg_emit;
  phase_t                 bg_phase;
  lpld_pkg::result_t      bg_res, r0, r1;
  logic [1:0]             n;
  logic                   do_begin, begin_slot1;

  function automatic logic [7:0] idx_mask(input logic [7:0] ci);
    logic [7:0] v;
    for (int i = 0; i < 8; i++) begin
      v[i] = (i < INDEX_BITS) ? ci[i] : 1'b0;
    end
    return v;
  endfunction

  // Values for starting the next item of the buffer
  always_comb begin
    start       = (step_opcode == lpld_pkg::OP_START);
    rem_dec     = bytes_remaining - LENGTH_BITS'(1);
    ibl_dec     = item_bytes_left - LENGTH_BITS'(1);
    rem_dec_ext = 32'(rem_dec);
    len         = {length_shift, step_byte};
    len_big     = len > rem_dec_ext;
    cur_last    = ({1'b0, current_item} + 9'd1) == {1'b0, item_count};
    bg_ci       = start ? 8'd0 : current_item + 8'd1;
    bg_rem      = start ? step_length[LENGTH_BITS-1:0] : rem_dec;
    bg_last     = ({1'b0, bg_ci} + 9'd1) == {1'b0, item_count};
    bg_empty    = (bg_rem == '0);
    bg_short    = bg_rem < LENGTH_BITS'(lpld_pkg::PREFIX_BYTES);
    bg_emit     = bg_last ? bg_empty : bg_short;
    if (bg_last) begin
      bg_phase = bg_empty ? PH_HALT : PH_BODY;
    end else begin
      bg_phase = bg_short ? PH_HALT : PH_PREFIX;
    end
    bg_res              = '0;
    bg_res.item_index   = idx_mask(bg_ci);
    bg_res.item_end     = bg_last;
    bg_res.error_code   = bg_last ? lpld_pkg::ERR_NONE : lpld_pkg::ERR_TRUNCATED;
  end

  always_comb begin
    phase_next           = phase;
    current_item_next    = current_item;
    bytes_remaining_next = bytes_remaining;
    item_bytes_left_next = item_bytes_left;
    length_shift_next    = length_shift;
    prefix_count_next    = prefix_count;
    r0                   = '0;
    r1                   = '0;
    n                    = 2'd0;
    do_begin             = 1'b0;
    begin_slot1          = 1'b0;

    if (step) begin
      if (start) begin
        bytes_remaining_next = step_length[LENGTH_BITS-1:0];
        current_item_next    = 8'd0;
        item_bytes_left_next = '0;
        length_shift_next    = '0;
        prefix_count_next    = 2'd0;
        if (item_count == 8'd0) begin
          phase_next = PH_HALT;
        end else begin
          do_begin = 1'b1;
        end
      end else begin
        case (phase)
          PH_PREFIX: begin
            bytes_remaining_next = rem_dec;
            if (prefix_count != 2'd3) begin
              length_shift_next = {length_shift[15:0], step_byte};
              prefix_count_next = prefix_count + 2'd1;
            end else begin
              prefix_count_next = 2'd0;
              r0.item_index     = idx_mask(current_item);
              if (len_big) begin
                r0.error_code = lpld_pkg::ERR_TOO_LONG;
                n             = 2'd1;
                phase_next    = PH_HALT;
              end else if (len == 32'd0) begin
                r0.item_end       = 1'b1;
                n                 = 2'd1;
                current_item_next = bg_ci;
                do_begin          = 1'b1;
                begin_slot1       = 1'b1;
              end else begin
                item_bytes_left_next = len[LENGTH_BITS-1:0];
                phase_next           = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            bytes_remaining_next = rem_dec;
            item_bytes_left_next = ibl_dec;
            r0.has_byte          = 1'b1;
            r0.payload_byte      = step_byte;
            r0.item_index        = idx_mask(current_item);
            n                    = 2'd1;
            if (ibl_dec == '0) begin
              r0.item_end = 1'b1;
              if (cur_last) begin
                phase_next = PH_HALT;
              end else begin
                current_item_next = bg_ci;
                do_begin          = 1'b1;
                begin_slot1       = 1'b1;
              end
            end
          end
          default: begin
            // drop data while idle or halted
          end
        endcase
      end

      if (do_begin) begin
        phase_next = bg_phase;
        if (bg_last) begin
          item_bytes_left_next = bg_rem;
        end
        if (bg_phase == PH_PREFIX) begin
          length_shift_next = '0;
          prefix_count_next = 2'd0;
        end
        if (bg_emit) begin
          if (begin_slot1) begin
            r1 = bg_res;
            n  = 2'd2;
          end else begin
            r0 = bg_res;
            n  = 2'd1;
          end
        end
      end
    end

    if (n == 2'd2) begin
      r1.last_result = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_result = 1'b1;
    end
  end

  assign res.count  = n;
  assign res.first  = r0;
  assign res.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      item_count      <= 8'd1;
      current_item    <= 8'd0;
      bytes_remaining <= '0;
      item_bytes_left <= '0;
      length_shift    <= '0;
      prefix_count    <= 2'd0;
    end else begin
      phase           <= phase_next;
      current_item    <= current_item_next;
      bytes_remaining <= bytes_remaining_next;
      item_bytes_left <= item_bytes_left_next;
      length_shift    <= length_shift_next;
      prefix_count    <= prefix_count_next;
      if (cfg_we) begin
        item_count <= cfg_data;
      end
    end
  end

endmodule

>>> rtl/lpld_checker.sv
// ---------------------------------------------------------------------------
// lpld_checker
// Port-level checks on the result stream of the deframer.
// ---------------------------------------------------------------------------
`include "length_prefixed_list_deframer_macros.svh"

module lpld_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  `LPLD_ASSERT(a_hold_stalled, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
  `LPLD_ASSERT(a_byte_no_error, m_tvalid && m_tuser[0] |-> m_tuser[2:1] == lpld_pkg::ERR_NONE, "byte result carries an error")
  `LPLD_ASSERT(a_error_shape, m_tvalid && m_tuser[2:1] != lpld_pkg::ERR_NONE |-> !m_tuser[0] && !m_tlast && m_tuser[3] && (m_tuser[2:1] == lpld_pkg::ERR_TRUNCATED || m_tuser[2:1] == lpld_pkg::ERR_TOO_LONG), "malformed error result")
  `LPLD_ASSERT(a_empty_zero, m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'd0, "payload set without a byte")
  `LPLD_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !m_tvalid, "result valid right after reset")

endmodule

bind length_prefixed_list_deframer lpld_checker u_lpld_checker (.*);

>>> tb/sv/length_prefixed_list_deframer_test.sv
// ---------------------------------------------------------------------------
// length_prefixed_list_deframer_test
// Drives start and data items into the deframer under random stalls on both
// stream sides. A scoreboard predicts the payload, item-end and error results
// of each accepted item and checks every result against them in order.
// ---------------------------------------------------------------------------
module length_prefixed_list_deframer_test;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 9;
  localparam int QUIET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_GAP      = 13;

  typedef enum logic [1:0] {
    SPLIT_IDLE,
    SPLIT_PREFIX,
    SPLIT_BODY,
    SPLIT_HALT
  } split_phase_t;

  class split_scoreboard;
    logic [7:0]        item_count;
    split_phase_t      phase;
    int unsigned       cur_item;
    logic [31:0]       remaining;
    logic [31:0]       item_left;
    logic [23:0]       len_shift;
    logic [1:0]        prefix_cnt;
    lpld_pkg::result_t expected_q[$];
    int unsigned       fail_count;

    function void clear();
      item_count = 8'd1;
      phase      = SPLIT_IDLE;
      cur_item   = 0;
      remaining  = '0;
      item_left  = '0;
      len_shift  = '0;
      prefix_cnt = '0;
      fail_count = 0;
      expected_q.delete();
    endfunction

    function void add_result(logic has, logic [7:0] b, logic fin, logic [1:0] err);
      lpld_pkg::result_t r;
      r.has_byte     = has;
      r.payload_byte = has ? b : 8'd0;
      r.item_index   = cur_item[7:0];
      r.item_end     = fin;
      r.error_code   = err;
      r.last_result  = 1'b0;
      expected_q = {expected_q, r};
    endfunction

    function bit on_last_item();
      return cur_item + 1 == item_count;
    endfunction

    function void open_item();
      if (on_last_item()) begin
        item_left = remaining;
        if (remaining == 0) begin
          add_result(1'b0, 8'd0, 1'b1, lpld_pkg::ERR_NONE);
          phase = SPLIT_HALT;
        end else begin
          phase = SPLIT_BODY;
        end
      end else if (remaining < lpld_pkg::PREFIX_BYTES) begin
        add_result(1'b0, 8'd0, 1'b0, lpld_pkg::ERR_TRUNCATED);
        phase = SPLIT_HALT;
      end else begin
        phase      = SPLIT_PREFIX;
        prefix_cnt = '0;
        len_shift  = '0;
      end
    endfunction

    function void note_input(logic op, logic [31:0] total, logic [7:0] b);
      int unsigned       first;
      logic [31:0]       len;
      lpld_pkg::result_t tail;
      first = expected_q.size();
      if (op == lpld_pkg::OP_START) begin
        remaining  = total;
        cur_item   = 0;
        item_left  = '0;
        len_shift  = '0;
        prefix_cnt = '0;
        if (item_count == 0) phase = SPLIT_HALT;
        else open_item();
      end else if (phase == SPLIT_PREFIX) begin
        remaining = remaining - 1;
        if (prefix_cnt < 3) begin
          len_shift  = {len_shift[15:0], b};
          prefix_cnt = prefix_cnt + 2'd1;
        end else begin
          len        = {len_shift, b};
          prefix_cnt = '0;
          if (len > remaining) begin
            add_result(1'b0, 8'd0, 1'b0, lpld_pkg::ERR_TOO_LONG);
            phase = SPLIT_HALT;
          end else if (len == 0) begin
            add_result(1'b0, 8'd0, 1'b1, lpld_pkg::ERR_NONE);
            cur_item++;
            open_item();
          end else begin
            item_left = len;
            phase     = SPLIT_BODY;
          end
        end
      end else if (phase == SPLIT_BODY) begin
        remaining = remaining - 1;
        item_left = item_left - 1;
        if (item_left == 0) begin
          add_result(1'b1, b, 1'b1, lpld_pkg::ERR_NONE);
          if (on_last_item()) begin
            phase = SPLIT_HALT;
          end else begin
            cur_item++;
            open_item();
          end
        end else begin
          add_result(1'b1, b, 1'b0, lpld_pkg::ERR_NONE);
        end
      end
      // flag the final result caused by this item
      if (expected_q.size() > first) begin
        tail = expected_q[expected_q.size() - 1];
        tail.last_result = 1'b1;
        expected_q[expected_q.size() - 1] = tail;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(logic [15:0] tdata, logic [3:0] tuser, logic tlast);
      lpld_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %h tlast %b",
                 $time, tdata, tuser, tlast);
        fail_count++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("has_byte", 8'(want.has_byte), 8'(tuser[0]));
      compare_field("error_code", 8'(want.error_code), 8'(tuser[2:1]));
      compare_field("last_result", 8'(want.last_result), 8'(tuser[3]));
      compare_field("payload_byte", want.payload_byte, tdata[7:0]);
      compare_field("item_index", want.item_index, tdata[15:8]);
      compare_field("item_end", 8'(want.item_end), 8'(tlast));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // total_length[31:0], data_byte[39:32]
  logic [0:0]  s_tuser = '0;   // opcode[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // payload_byte[7:0], item_index[15:8]
  logic [3:0]  m_tuser;        // has_byte[0], error_code[2:1], last_result[3]
  logic        m_tlast;        // item_end

  split_scoreboard sb;
  int unsigned     send_gap_max = MAX_GAP;
  int unsigned     recv_gap_max = MAX_GAP;
  int unsigned     cycles = 0;

  length_prefixed_list_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("length_prefixed_list_deframer test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Result side: stall a random number of cycles before each result.
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      stall = $urandom_range(0, recv_gap_max);
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  task automatic send_item(logic op, logic [31:0] total, logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {b, total};
    do @(posedge clk); while (!s_tready);
    sb.note_input(op, total, b);
  endtask

  // Hold the sender until every expected result is out and the pipe is empty.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [7:0] value);
    settle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    sb.item_count = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One buffer of prefixed items with random content, sometimes flawed.
  task automatic send_buffer(int unsigned max_len, output int unsigned sent);
    logic [7:0]  bytes_q[$];
    logic [31:0] field;
    logic [31:0] total;
    int unsigned parts, plen, flaw, bad_item, keep;
    parts = (sb.item_count != 0 && sb.item_count <= 7) ? sb.item_count :
            $urandom_range(1, 4);
    flaw     = $urandom_range(0, 11);
    bad_item = $urandom_range(0, parts - 1);
    for (int unsigned i = 0; i < parts; i++) begin
      plen = $urandom_range(0, max_len);
      if (i + 1 != sb.item_count) begin
        field = (flaw == 0 && i == bad_item) ? plen + $urandom_range(1, 4) : plen;
        for (int k = 3; k >= 0; k--) bytes_q = {bytes_q, field[8*k +: 8]};
      end
      repeat (plen) bytes_q = {bytes_q, 8'($urandom)};
    end
    total = bytes_q.size();
    keep  = bytes_q.size();
    case (flaw)
      1: total = (total > 6) ? total - $urandom_range(1, 6) : 0;
      2: keep = $urandom_range(0, bytes_q.size());
      3: repeat ($urandom_range(1, 3)) bytes_q = {bytes_q, 8'($urandom)};
      4: total = $urandom;
      default: ;
    endcase
    if (flaw == 3) keep = bytes_q.size();
    send_item(lpld_pkg::OP_START, total, 8'($urandom));
    for (int unsigned i = 0; i < keep; i++) send_item(lpld_pkg::OP_DATA, $urandom, bytes_q[i]);
    sent = keep + 1;
  endtask

  initial begin
    logic [7:0]  counts[9];
    int unsigned sent, phase_items, random_items, ph;
    counts = '{8'd2, 8'd1, 8'd3, 8'd255, 8'd4, 8'd2, 8'd7, 8'd1, 8'd5};
    sb = new;
    sb.clear();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // data while idle is dropped
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'hC3);
    // one item: empty buffer, then the widest length abandoned by a new start
    send_item(lpld_pkg::OP_START, 32'h0, 8'hFF);
    send_item(lpld_pkg::OP_START, 32'hFFFF_FFFF, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'hFFFF_FFFF, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'hFF);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'hA5);
    send_item(lpld_pkg::OP_START, 32'd2, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h5A);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h3C);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h11);

    // zero items: start halts at once
    write_count(8'd0);
    send_item(lpld_pkg::OP_START, 32'hFFFF_FFFF, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h77);

    // two items: truncated length on start, length too long, two empty items
    write_count(8'd2);
    send_item(lpld_pkg::OP_START, 32'd3, 8'h00);
    send_item(lpld_pkg::OP_START, 32'd5, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h00);
    send_item(lpld_pkg::OP_DATA, 32'h0, 8'h02);
    send_item(lpld_pkg::OP_START, 32'd4, 8'h00);
    repeat (4) send_item(lpld_pkg::OP_DATA, 32'h0, 8'h00);

    random_items = 0;
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      write_count(counts[ph % 9]);
      send_gap_max = (ph % 3 == 1) ? 0 : MAX_GAP;
      recv_gap_max = (ph % 4 == 2) ? 0 : MAX_GAP;
      phase_items = 0;
      while (phase_items < 50) begin
        send_buffer(($urandom_range(0, 7) == 0) ? 40 : 6, sent);
        phase_items += sent;
        if (ph == 1 && phase_items == sent) settle();
      end
      random_items += phase_items;
      ph++;
    end

    settle();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("length_prefixed_list_deframer test passed");
    end else begin
      $display("length_prefixed_list_deframer test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lpld_pkg.sv
rtl/lpld_core.sv
rtl/length_prefixed_list_deframer.sv
rtl/lpld_checker.sv
tb/sv/length_prefixed_list_deframer_test.sv
